### rtl/core/integer_to_digit_string_assert.svh
// Assertion helpers included by integer_to_digit_string.sv, the RTL file of the digit string block.
`ifndef INTEGER_TO_DIGIT_STRING_ASSERT_SVH
`define INTEGER_TO_DIGIT_STRING_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define ITDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ITDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/itds_pkg.sv
`default_nettype none

package itds_pkg;

  // Default width of the value to convert.
  localparam int VALUE_BITS_DEF = 31;

  // Field widths.
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Register indexes.
  localparam logic REG_RADIX = 1'b0;

  // Radix limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
  localparam logic [CHAR_W-1:0] DECIMAL_LIMIT     = 7'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DECIMAL = 6'd9;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Map a digit value to its ASCII character.
  function automatic char_t digit_to_ascii(input digit_t d);
    char_t dx;
    dx = {1'b0, d};
    if (d <= DIGIT_MAX_DECIMAL) begin
      return dx + CHAR_ZERO;
    end
    return dx - DECIMAL_LIMIT + CHAR_A;
  endfunction

endpackage

`default_nettype wire

### rtl/core/integer_to_digit_string.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------
// in       | input     | in_valid / in_ready     | in_value
// out      | output    | out_valid / out_ready   | out_digit_char, out_last
// cfg      | input     | APB psel/penable/pready | paddr, pwdata, prdata (radix)
//
// Each digit is found by the shared restoring divider (one quotient bit per cycle);
// once all digits are stored, each is read back through the registered digit RAM read
// port (S_RD, then S_LOAD) into the output register, most significant digit first.
// in_ready is high only while idle; the last digit may still wait in the output register.
// Reset (synchronous, active low) returns the radix to ten and the sequencer to idle.
// A stalled output holds the emit sequence until out_ready rises.
`default_nettype none

module integer_to_digit_string
  import itds_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input requests.
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  // Result requests.
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CHAR_W-1:0]     out_digit_char,
  output logic                       out_last,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready
);

`include "integer_to_digit_string_assert.svh"

  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int BIT_W  = $clog2(VALUE_BITS);
  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_BITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0]            state_r, state_nxt;
  radix_t                radix_r;
  radix_t                eff_radix_r, eff_radix_nxt;
  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  digit_t                rem_r, rem_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      emit_r, emit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  char_t                 out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [DIGIT_W:0]      trial;
  logic [DIGIT_W:0]      diff;
  logic                  qbit;
  digit_t                rem_step;
  logic [VALUE_BITS-1:0] quot_shift;
  logic                  ram_we;
  logic [CNT_W-1:0]      emit_prev;
  digit_t                ram_rdata;
  logic                  out_room;
  logic                  cfg_write;

  // Configuration register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_RADIX) ? {{(APB_DW-RADIX_W){1'b0}}, radix_r}
                                             : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_write && paddr[2] == REG_RADIX) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  // Clamp the radix into the supported range at the start of an item.
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff_radix_nxt = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix_nxt = RADIX_MAX;
    end else begin
      eff_radix_nxt = radix_r;
    end
  end

  // Shared divider step: shift in one dividend bit and try a subtraction.
  assign trial      = {rem_r, quot_r[VALUE_BITS-1]};
  assign diff       = trial - {1'b0, eff_radix_r};
  assign qbit       = (trial >= {1'b0, eff_radix_r});
  assign rem_step   = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign quot_shift = {quot_r[VALUE_BITS-2:0], qbit};

  assign ram_we    = (state_r == S_DIV) && (bit_r == LAST_BIT);
  assign emit_prev = emit_r - 1'b1;
  assign out_room  = !out_valid_r || out_ready;

  itds_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (rem_step),
    .raddr (emit_prev[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer: divide digit by digit, then emit most significant first.
  always_comb begin
    state_nxt     = state_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_step;
    bit_nxt       = bit_r;
    count_nxt     = count_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV;
          quot_nxt  = in_value;
          rem_nxt   = '0;
          bit_nxt   = '0;
          count_nxt = '0;
        end else begin
          rem_nxt = rem_r;
        end
      end
      S_DIV: begin
        quot_nxt = quot_shift;
        if (bit_r == LAST_BIT) begin
          count_nxt = count_r + 1'b1;
          bit_nxt   = '0;
          if (quot_shift == '0) begin
            emit_nxt  = count_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            rem_nxt = '0;
          end
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_RD: begin
        rem_nxt   = rem_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rem_nxt = rem_r;
        if (out_room) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(ram_rdata);
          out_last_nxt  = (emit_r == CNT_W'(1));
          emit_nxt      = emit_prev;
          state_nxt     = (emit_r == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        rem_nxt   = rem_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= '0;
      count_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      count_r     <= count_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == S_IDLE) begin
      eff_radix_r <= eff_radix_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  // The partial remainder always stays below the divisor.
  `ITDS_ASSERT_NOW(a_rem_below_radix, state_r == S_DIV, rem_r < eff_radix_r, "rem >= radix")
  // Each finished division stores exactly one more digit.
  `ITDS_ASSERT_NEXT(a_digit_stored, ram_we, count_r == $past(count_r) + 1'b1, "count stuck")
  // An accepted item starts the divider and blocks further input.
  `ITDS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_DIV && !in_ready, "stuck")
  // The emit sequence never runs past the stored digits.
  `ITDS_ASSERT_NOW(a_emit_in_range, state_r == S_LOAD, emit_r != '0 && emit_r <= count_r, "range")

endmodule

`default_nettype wire

### rtl/core/itds_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module itds_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
